FILE: hw/rtl/stun_binding_response_parser_top_assert.svh
// assertion macros for the stun binding response parser
// expects i_clk and i_rst_n in the scope of each use
`ifndef STUN_BINDING_RESPONSE_PARSER_TOP_ASSERT_SVH
`define STUN_BINDING_RESPONSE_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbrp assertion failed");

// next-cycle implication, checked outside reset
`define SBRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbrp assertion failed");

`endif

FILE: hw/rtl/sbrp_pkg.sv
// shared types and constants of the stun binding response parser
// no dependencies
`default_nettype none

package sbrp_pkg;

    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] MAX_DATAGRAM = 17'd65535;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 17'd20;
    localparam logic [COUNT_W-1:0] KIND_END     = 17'd2;
    localparam logic [COUNT_W-1:0] LENGTH_END   = 17'd4;
    localparam logic [COUNT_W-1:0] ID_START     = 17'd4;

    localparam logic [15:0] KIND_BINDING_RESPONSE = 16'h0101;
    localparam logic [15:0] KIND_MAPPED_ADDRESS   = 16'h0001;
    localparam logic [15:0] MAPPED_LENGTH         = 16'd8;
    localparam logic [15:0] ADDRESS_OFFSET        = 16'd4;
    localparam logic [15:0] ATTR_HDR_LAST         = 16'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LOWER = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK_ADDR      = 3'd0,
        ST_OK_NO_ADDR   = 3'd1,
        ST_SHORT        = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_WRONG_ID     = 3'd4,
        ST_WRONG_TYPE   = 3'd5
    } t_status;

    typedef struct packed {
        logic step;
        logic clear;
    } t_walk_ctl;

    typedef struct packed {
        logic        seen;
        logic [31:0] found;
    } t_walk_res;

endpackage

`default_nettype wire

FILE: hw/rtl/stun_binding_response_parser_top.sv
// result: valid in the cycle after the transfer of the last byte
// throughput: one byte per cycle while o_stall is low, including back-to-back datagrams; set by
//   the single state update between the byte transfer and the result register
// reset (synchronous, active low): clears the expected id, the per-datagram header state and
//   the result valid flag, but not the result payload; no clearing pass
// depends on sbrp_pkg, sbrp_attr_walker and the assertion macro header
`default_nettype none

module stun_binding_response_parser_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [sbrp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                    i_cfg_data,
    // byte input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_last_byte,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [sbrp_pkg::STATUS_W-1:0]       o_status,
    output logic [31:0]                         o_public_address
);
    import sbrp_pkg::*;

    `include "stun_binding_response_parser_top_assert.svh"

    // configured transaction id
    logic [63:0]        r_id_upper;
    logic [63:0]        r_id_lower;

    // per-datagram header state
    logic [COUNT_W-1:0] r_count, n_count;
    logic [15:0]        r_decl_len, n_decl_len;
    logic [15:0]        r_msg_kind, n_msg_kind;
    logic               r_id_mismatch, n_id_mismatch;

    // result register
    logic               r_out_valid;
    t_status            r_status;
    logic [31:0]        r_addr;

    logic               w_accept;
    logic               w_in_range;
    logic [127:0]       w_id;
    logic [3:0]         w_id_k;
    logic [3:0]         w_id_sel;
    logic [7:0]         w_id_byte;
    logic [COUNT_W-1:0] w_id_pos;
    logic [COUNT_W-1:0] w_len;
    logic [COUNT_W-1:0] w_expect_len;
    t_status            w_status;
    t_walk_ctl          w_walk_ctl;
    t_walk_res          w_walk_res;

    // a byte waits only while a finished result is held by the consumer
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // bytes past the receive buffer size are counted but not parsed
    assign w_in_range = r_count < MAX_DATAGRAM;

    // transaction id byte k sits at bits 127-8k down to 120-8k
    assign w_id      = {r_id_upper, r_id_lower};
    assign w_id_pos  = r_count - ID_START;
    assign w_id_k    = w_id_pos[3:0];
    assign w_id_sel  = 4'd15 - w_id_k;
    assign w_id_byte = w_id[{w_id_sel, 3'b000} +: 8];

    always_comb begin
        n_msg_kind    = r_msg_kind;
        n_decl_len    = r_decl_len;
        n_id_mismatch = r_id_mismatch;
        w_walk_ctl.step  = 1'b0;
        w_walk_ctl.clear = w_accept && i_last_byte;
        if (w_in_range) begin
            if (r_count < KIND_END) begin
                n_msg_kind = (r_count == '0) ? {i_data_byte, 8'h00}
                                             : (r_msg_kind | {8'h00, i_data_byte});
            end else if (r_count < LENGTH_END) begin
                n_decl_len = (r_count == KIND_END) ? {i_data_byte, 8'h00}
                                                   : (r_decl_len | {8'h00, i_data_byte});
            end else if (r_count < HEADER_BYTES) begin
                if (i_data_byte != w_id_byte) begin
                    n_id_mismatch = 1'b1;
                end
            end else begin
                // attribute area
                w_walk_ctl.step = w_accept;
            end
        end
        // saturating byte count
        n_count = (r_count < COUNT_MAX) ? (r_count + 17'd1) : r_count;
    end

    sbrp_attr_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_walk_ctl),
        .i_data  (i_data_byte),
        .o_res   (w_walk_res)
    );

    // final checks use the state as it stands after this byte
    assign w_len        = (n_count > MAX_DATAGRAM) ? MAX_DATAGRAM : n_count;
    assign w_expect_len = {1'b0, n_decl_len} + HEADER_BYTES;

    always_comb begin
        if (w_len < HEADER_BYTES) begin
            w_status = ST_SHORT;
        end else if (w_len != w_expect_len) begin
            w_status = ST_LEN_MISMATCH;
        end else if (n_id_mismatch) begin
            w_status = ST_WRONG_ID;
        end else if (n_msg_kind != KIND_BINDING_RESPONSE) begin
            w_status = ST_WRONG_TYPE;
        end else if (w_walk_res.seen) begin
            w_status = ST_OK_ADDR;
        end else begin
            w_status = ST_OK_NO_ADDR;
        end
    end

    // control state, id registers and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_upper    <= '0;
            r_id_lower    <= '0;
            r_count       <= '0;
            r_decl_len    <= '0;
            r_msg_kind    <= '0;
            r_id_mismatch <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ID_UPPER: r_id_upper <= i_cfg_data;
                    CFG_ID_LOWER: r_id_lower <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (i_last_byte) begin
                    // datagram done: start fresh for the next one
                    r_count       <= '0;
                    r_decl_len    <= '0;
                    r_msg_kind    <= '0;
                    r_id_mismatch <= 1'b0;
                end else begin
                    r_count       <= n_count;
                    r_decl_len    <= n_decl_len;
                    r_msg_kind    <= n_msg_kind;
                    r_id_mismatch <= n_id_mismatch;
                end
            end
            if (w_accept && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_status <= w_status;
            r_addr   <= (w_status == ST_OK_ADDR) ? w_walk_res.found : 32'd0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_public_address = r_addr;

    // an address is only reported with the ok-with-address status
    `SBRP_ASSERT_NOW(a_addr_only_ok, o_valid && (o_status != ST_OK_ADDR), o_public_address == 32'd0)
    // a last-byte transfer always yields a result next cycle
    `SBRP_ASSERT_NEXT(a_last_gives_result, w_accept && i_last_byte, o_valid)
    // a last-byte transfer clears the header state
    `SBRP_ASSERT_NEXT(a_last_clears, w_accept && i_last_byte, (r_count == '0) && !r_id_mismatch)

endmodule

`default_nettype wire

FILE: hw/rtl/sbrp_attr_walker.sv
// type-length-value attribute walker, captures mapped ipv4 addresses
// depends on sbrp_pkg
`default_nettype none

module sbrp_attr_walker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sbrp_pkg::t_walk_ctl i_ctl,
    input  wire logic [7:0]          i_data,
    output sbrp_pkg::t_walk_res      o_res
);
    import sbrp_pkg::*;

    logic        r_in_value, n_in_value;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_kind, n_kind;
    logic [15:0] r_len, n_len;
    logic [31:0] r_cand, n_cand;
    logic [31:0] r_found, n_found;
    logic        r_seen, n_seen;
    logic        w_mapped;
    logic        w_done;

    assign w_mapped = (r_kind == KIND_MAPPED_ADDRESS) && (r_len == MAPPED_LENGTH);
    assign w_done   = ({1'b0, r_offset} + 17'd1) >= {1'b0, r_len};

    always_comb begin
        n_in_value = r_in_value;
        n_offset   = r_offset;
        n_kind     = r_kind;
        n_len      = r_len;
        n_cand     = r_cand;
        n_found    = r_found;
        n_seen     = r_seen;
        if (i_ctl.step) begin
            if (!r_in_value) begin
                // attribute header: type then length, big-endian
                case (r_offset[1:0])
                    2'd0:    n_kind = {i_data, 8'h00};
                    2'd1:    n_kind = r_kind | {8'h00, i_data};
                    2'd2:    n_len  = {i_data, 8'h00};
                    default: n_len  = r_len | {8'h00, i_data};
                endcase
                if (r_offset >= ATTR_HDR_LAST) begin
                    n_offset   = '0;
                    n_in_value = (n_len != 16'd0);
                end else begin
                    n_offset = r_offset + 16'd1;
                end
            end else begin
                if (w_mapped && r_offset >= ADDRESS_OFFSET) begin
                    n_cand = {r_cand[23:0], i_data};
                end
                if (w_done) begin
                    if (w_mapped) begin
                        n_found = n_cand;
                        n_seen  = 1'b1;
                    end
                    n_in_value = 1'b0;
                    n_offset   = '0;
                end else begin
                    n_offset = r_offset + 16'd1;
                end
            end
        end
    end

    assign o_res = {n_seen, n_found};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_in_value <= 1'b0;
            r_offset   <= '0;
            r_kind     <= '0;
            r_len      <= '0;
            r_seen     <= 1'b0;
        end else begin
            r_in_value <= n_in_value;
            r_offset   <= n_offset;
            r_kind     <= n_kind;
            r_len      <= n_len;
            r_seen     <= n_seen;
        end
    end

    // address bytes are fully rewritten before any capture
    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_found <= n_found;
    end

endmodule

`default_nettype wire
